>>> design/alist_pkg.sv
// alist_pkg: shared widths, operation codes and structs for the array list block
// used by alist_cell, alist_scan and array_list_insert_delete_locate
// depends on nothing
package alist_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 2;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 7;
  localparam int SCAN_W    = 8;
  localparam int SCAN_EW   = $clog2(SCAN_W);

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_LOCATE = 2'd2;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

  // current group of the match scan
  typedef struct packed {
    logic hit;
    logic last;
  } scan_st_t;

  typedef struct packed {
    logic             status;
    logic [POS_W-1:0] location;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

>>> design/array_list_insert_delete_locate.sv
// insert and unknown codes: result registered in the output buffer; one insert per cycle while results drain
// delete and locate: result goes to the output buffer once it is set by the match scan
//   that walks the cell flags eight entries per cycle; it stops at the first group with a hit or at the last group
// a two-beat output buffer lets the next item in while a result waits
// reset clears the length, the scan pointer and the handshake state; entries are not cleared
module array_list_insert_delete_locate
  import alist_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  operation,
  input  logic [POS_W-1:0] position,
  input  logic [VAL_W-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             status,
  output logic [POS_W-1:0] location,
  output logic [CNT_W-1:0] count
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam int NG = (DEPTH + SCAN_W - 1) / SCAN_W;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state, state_next;

  logic [LW-1:0]        len;
  logic [LW-1:0]        len_next;
  logic                 is_loc;
  logic                 in_fire;
  logic [CW-1:0]        pos_c;
  logic [CW-1:0]        len_c;
  logic [CW-1:0]        pos_m1;
  logic                 ins_ok;
  cell_ctl_t            ctl;
  logic [VAL_W-1:0]     ent   [DEPTH];
  logic [DEPTH-1:0]     match;
  logic                 scan_load;
  logic                 adv;
  scan_st_t             scan_st;
  logic [GW+SCAN_EW-1:0] scan_idx;
  logic [31:0]          loc_w;
  logic [31:0]          len_w;
  logic [31:0]          len_next_w;
  logic                 push;
  res_t                 res;
  res_t                 out_r;
  res_t                 hold;
  logic                 hold_valid;
  logic                 pop;

  assign in_ready = (state == S_IDLE) && !hold_valid;
  assign in_fire  = in_valid && in_ready;

  assign pos_c  = CW'(position);
  assign len_c  = CW'(len);
  assign pos_m1 = pos_c - CW'(1);
  assign ins_ok = (op_t'(operation) == OP_INSERT) && (pos_c != '0)
                  && (pos_c <= len_c + CW'(1)) && (len != LW'(DEPTH));

  assign ctl.ins   = in_fire && ins_ok;
  assign ctl.del   = in_fire && (op_t'(operation) == OP_DELETE);
  assign ctl.value = value;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = ent[k-1];
    end
    alist_cell #(
      .DEPTH (DEPTH),
      .IDX   (k)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .pos_m1 (pos_m1),
      .len    (len_c),
      .prev   (prev),
      .entry  (ent[k]),
      .match  (match[k])
    );
  end

  assign scan_load = in_fire && ((op_t'(operation) == OP_DELETE)
                                 || (op_t'(operation) == OP_LOCATE));

  alist_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .load     (scan_load),
    .adv      (adv),
    .flags_in (match),
    .st       (scan_st),
    .idx      (scan_idx)
  );

  assign len_next   = ctl.ins ? len + LW'(1) : len;
  assign loc_w      = 32'(scan_idx) + 32'd1;
  assign len_w      = 32'(len);
  assign len_next_w = 32'(len_next);

  always_comb begin
    state_next = state;
    push       = 1'b0;
    adv        = 1'b0;
    res        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (scan_load) begin
            state_next = S_SCAN;
          end else begin
            push       = 1'b1;
            res.status = !ins_ok;
            res.count  = len_next_w[CNT_W-1:0];
          end
        end
      end
      S_SCAN: begin
        if (scan_st.hit || scan_st.last) begin
          if (!hold_valid) begin
            push         = 1'b1;
            res.status   = !scan_st.hit;
            res.location = (is_loc && scan_st.hit) ? loc_w[POS_W-1:0] : '0;
            res.count    = len_w[CNT_W-1:0];
            state_next   = S_IDLE;
          end
        end else begin
          adv = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_load) begin
      is_loc <= (op_t'(operation) == OP_LOCATE);
    end
  end

  // output register with one skid beat behind it
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_r     <= res;
        out_valid <= 1'b1;
      end else begin
        hold       <= res;
        hold_valid <= 1'b1;
      end
    end else if (pop) begin
      if (hold_valid) begin
        out_r      <= hold;
        hold_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status   = out_r.status;
  assign location = out_r.location;
  assign count    = out_r.count;

`ifndef SYNTH
  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("skid beat held without an output beat");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(DEPTH))
    else $error("list length beyond store depth");

  a_len_kept: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (op_t'(operation) != OP_INSERT)) |=> (len == $past(len)))
    else $error("length changed by a non-insert beat");

  a_loc_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (location != '0)) |-> (status == 1'b0))
    else $error("location reported with failing status");
`endif

endmodule

>>> design/alist_cell.sv
// alist_cell: one list entry; loads the value or takes its left neighbor on insert, clears on delete match
// depends on alist_pkg
module alist_cell
  import alist_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int LW   = $clog2(DEPTH + 1),
  localparam int CW   = ((LW > POS_W) ? LW : POS_W) + 1
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CW-1:0]    pos_m1,
  input  logic [CW-1:0]    len,
  input  logic [VAL_W-1:0] prev,
  output logic [VAL_W-1:0] entry,
  output logic             match
);

  logic [CW-1:0] here;
  logic          sel_load;
  logic          sel_shift;

  assign here      = CW'(IDX);
  assign sel_load  = (here == pos_m1);
  assign sel_shift = (here > pos_m1) && (here <= len);
  assign match     = (here < len) && (entry == ctl.value);

  always_ff @(posedge clk) begin
    if (ctl.ins && sel_load) begin
      entry <= ctl.value;
    end else if (ctl.ins && sel_shift) begin
      entry <= prev;
    end else if (ctl.del && match) begin
      entry <= '0;
    end
  end

endmodule

>>> design/alist_scan.sv
// alist_scan: holds the match flags of all cells and walks them one group per cycle while adv is set
// depends on alist_pkg
module alist_scan
  import alist_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int NG   = (DEPTH + SCAN_W - 1) / SCAN_W,
  localparam int NB   = NG * SCAN_W,
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  adv,
  input  logic [DEPTH-1:0]      flags_in,
  output scan_st_t              st,
  output logic [GW+SCAN_EW-1:0] idx
);

  logic [NB-1:0]      flags;
  logic [GW-1:0]      grp;
  logic [SCAN_W-1:0]  grp_bits [NG];
  logic [SCAN_W-1:0]  cur;
  logic [SCAN_EW-1:0] enc;

  always_ff @(posedge clk) begin
    if (load) begin
      flags <= NB'(flags_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
    end else if (load) begin
      grp <= '0;
    end else if (adv) begin
      grp <= grp + GW'(1);
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_bits[g] = flags[g*SCAN_W +: SCAN_W];
    end
  end

  assign cur = grp_bits[grp];

  // lowest set bit of the group
  always_comb begin
    enc = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (cur[i]) begin
        enc = SCAN_EW'(i);
      end
    end
  end

  assign st.hit  = |cur;
  assign st.last = (grp == GW'(NG - 1));
  assign idx     = {grp, enc};

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for array_list_insert_delete_locate (insert, delete, locate)
// predicts each result from its own copy of the list and checks every output beat in order
// depends on alist_pkg and the array_list_insert_delete_locate module
module tb_top;
  import alist_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam op_t OP_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  logic             out_valid;
  logic             out_ready;
  logic             status;
  logic [POS_W-1:0] location;
  logic [CNT_W-1:0] count;

  bit steady = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  logic [VAL_W-1:0] list_mem [DEPTH];
  int list_len = 0;
  res_t list_results_due [$];

  array_list_insert_delete_locate #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .location(location),
    .count(count)
  );

  always #5 clk = ~clk;

  function automatic res_t apply_list_op(input op_t op, input logic [POS_W-1:0] pos,
                                         input logic [VAL_W-1:0] val);
    res_t r;
    int p;
    int k;
    r.status = 1'b1;
    r.location = '0;
    p = pos;
    case (op)
      OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
          for (k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = val;
          list_len++;
          r.status = 1'b0;
        end
      end
      OP_DELETE: begin
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == val) begin
            list_mem[k] = '0;
            r.status = 1'b0;
          end
        end
      end
      OP_LOCATE: begin
        for (k = 0; k < list_len; k++) begin
          if (list_mem[k] == val) begin
            r.location = POS_W'(k + 1);
            r.status = 1'b0;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  // one input beat: random idle, then hold until accepted
  task automatic send_list_op(input op_t op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (!in_ready);
    list_results_due.push_back(apply_list_op(op, pos, val));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (list_results_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 4 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
    case (r)
      5: return '0;
      6: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      7: return VAL_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_list_op(OP_LOCATE, 7'd0, 32'd5);
    send_list_op(OP_DELETE, 7'd0, 32'd0);
    send_list_op(OP_INSERT, 7'd0, 32'd7);
    send_list_op(OP_INSERT, 7'd2, 32'd7);
  endtask

  task automatic test_insert_positions();
    send_list_op(OP_INSERT, 7'd1, 32'h7fff_ffff);
    send_list_op(OP_INSERT, 7'd1, 32'h8000_0000);
    send_list_op(OP_INSERT, 7'd3, 32'hffff_ffff);
    send_list_op(OP_INSERT, 7'd2, 32'h0000_0000);
    send_list_op(OP_INSERT, 7'd127, 32'h0000_0001);
    send_list_op(OP_INSERT, 7'd64, 32'h0000_0002);
    send_list_op(OP_INSERT, 7'd5, 32'h5555_5555);
    send_list_op(OP_INSERT, 7'd1, 32'haaaa_aaaa);
  endtask

  task automatic test_locate_delete();
    send_list_op(OP_LOCATE, 7'd0, 32'h7fff_ffff);
    send_list_op(OP_LOCATE, 7'd127, 32'hffff_ffff);
    send_list_op(OP_LOCATE, 7'd0, 32'd12345);
    send_list_op(OP_DELETE, 7'd0, 32'h8000_0000);
    send_list_op(OP_LOCATE, 7'd0, 32'h0000_0000);
    send_list_op(OP_DELETE, 7'd0, 32'h0000_0000);
    send_list_op(OP_DELETE, 7'd0, 32'd99);
    send_list_op(OP_LOCATE, 7'd0, 32'h5555_5555);
  endtask

  task automatic test_unknown_op();
    send_list_op(OP_UNKNOWN, 7'd127, 32'hffff_ffff);
    send_list_op(OP_UNKNOWN, 7'd1, 32'h0000_0000);
  endtask

  task automatic test_random_mix(input int n);
    int i;
    int r;
    logic [POS_W-1:0] pos;
    for (i = 0; i < n; i++) begin
      steady = (i >= n / 3) && (i < n / 2);
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(1, list_len + 1));
      else pos = POS_W'($urandom_range(0, 127));
      if (r < 10) send_list_op(OP_INSERT, pos, pick_value());
      else if (r < 35) send_list_op(OP_DELETE, POS_W'($urandom), pick_value());
      else if (r < 92) send_list_op(OP_LOCATE, POS_W'($urandom), pick_value());
      else send_list_op(OP_UNKNOWN, POS_W'($urandom), $urandom);
    end
    steady = 1'b0;
  endtask

  task automatic test_full_store();
    while (list_len < DEPTH)
      send_list_op(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
    send_list_op(OP_INSERT, POS_W'(list_len + 1), $urandom);
    send_list_op(OP_INSERT, 7'd1, $urandom);
    send_list_op(OP_LOCATE, 7'd0, list_mem[DEPTH-1]);
    send_list_op(OP_DELETE, 7'd0, list_mem[0]);
    send_list_op(OP_LOCATE, 7'd0, 32'h0000_0000);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (list_results_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: status %0d location %0d count %0d",
                   status, location, count);
        mismatch_count++;
      end else begin
        exp_res = list_results_due.pop_front();
        if (exp_res.status !== status || exp_res.location !== location ||
            exp_res.count !== count) begin
          if (mismatch_count < 10)
            $display("mismatch: status %0d/%0d location %0d/%0d count %0d/%0d (exp/got)",
                     exp_res.status, status, exp_res.location, location,
                     exp_res.count, count);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < DEPTH; k++) list_mem[k] = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_INSERT;
    position = '0;
    value = '0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_list();
    test_insert_positions();
    test_locate_delete();
    test_unknown_op();
    wait_drain();
    test_random_mix(1900);
    wait_drain();
    test_full_store();
    wait_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && list_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/alist_pkg.sv
design/alist_cell.sv
design/alist_scan.sv
design/array_list_insert_delete_locate.sv
verif/tb_top.sv
